FILE: src/mhtz_pkg.sv
package mhtz_pkg;

  // window store depth
  localparam int MAX_WINDOW = 8;
  // counter wide enough to hold MAX_WINDOW itself
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  // index into the cell row
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // common width for the window count clamp
  localparam int CLAMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam int TEMP_W     = 16;
  localparam int HYST_W     = 15;
  localparam int WC_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [TEMP_W-1:0] ERROR_TEMP = -16'sd9999;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KIND  = 3'd5;

  typedef enum logic [1:0] {
    ZONE_GREEN    = 2'd0,
    ZONE_YELLOW   = 2'd1,
    ZONE_RED_LOW  = 2'd2,
    ZONE_RED_HIGH = 2'd3
  } zone_t;

  // per-cycle command to every cell of the sort row
  typedef struct packed {
    logic ins;  // insert the broadcast key
    logic clr;  // empty the row
  } cell_ctl_t;

endpackage

FILE: src/mhtz_if.sv
interface mhtz_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mhtz_pkg::TEMP_W-1:0]   raw_sample;
  logic                                 read_failed;

  modport source (output valid, raw_sample, read_failed, input ready);
  modport sink   (input valid, raw_sample, read_failed, output ready);
endinterface

interface mhtz_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mhtz_pkg::TEMP_W-1:0]   temperature;
  logic [1:0]                           zone;
  logic                                 led_green;
  logic                                 led_yellow;
  logic                                 led_red;
  logic                                 sensor_error;

  modport source (output valid, temperature, zone, led_green, led_yellow, led_red,
                  sensor_error, input ready);
  modport sink   (input valid, temperature, zone, led_green, led_yellow, led_red,
                  sensor_error, output ready);
endinterface

FILE: src/mhtz_cell.sv
module mhtz_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  mhtz_pkg::cell_ctl_t               ctl,
  input  logic signed [mhtz_pkg::TEMP_W-1:0] key,
  input  logic signed [mhtz_pkg::TEMP_W-1:0] left_val,
  input  logic                              left_valid,
  input  logic                              left_full,
  output logic signed [mhtz_pkg::TEMP_W-1:0] val,
  output logic                              valid
);
  import mhtz_pkg::*;

  logic left_gt;
  logic self_gt;

  // left neighbor larger than key: it moves one place right into this cell
  assign left_gt = left_valid && (left_val > key);
  // empty cell counts as +inf
  assign self_gt = !valid || (val > key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      if (left_gt) begin
        val   <= left_val;
        valid <= 1'b1;
      end else if (self_gt && left_full) begin
        val   <= key;
        valid <= 1'b1;
      end
    end
  end

endmodule

FILE: src/mhtz_chain.sv
module mhtz_chain (
  input  logic                               clk,
  input  logic                               rst,
  input  mhtz_pkg::cell_ctl_t                ctl,
  input  logic signed [mhtz_pkg::TEMP_W-1:0] key,
  input  logic [mhtz_pkg::IDX_W-1:0]         sel,
  output logic signed [mhtz_pkg::TEMP_W-1:0] median
);
  import mhtz_pkg::*;

  logic signed [TEMP_W-1:0] vals  [MAX_WINDOW];
  logic                     valids[MAX_WINDOW];

  // ascending sorted row; filled cells form a prefix
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      mhtz_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .key        (key),
        .left_val   ('0),
        .left_valid (1'b0),
        .left_full  (1'b1),
        .val        (vals[i]),
        .valid      (valids[i])
      );
    end else begin : g_body
      mhtz_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .key        (key),
        .left_val   (vals[i-1]),
        .left_valid (valids[i-1]),
        .left_full  (valids[i-1]),
        .val        (vals[i]),
        .valid      (valids[i])
      );
    end
  end

  assign median = vals[sel];

endmodule

FILE: src/median_hysteresis_thermal_zone.sv
// Channel  | Dir | Beat payload
// ---------+-----+-------------------------------------------------------------
// in_ch    | in  | raw_sample (s16), read_failed
// out_ch   | out | temperature (s16), zone (2b), led_green/yellow/red, sensor_error
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only, no read-back)
//
// Per beat: accept, insert; a beat that does not fill the window ends there, one that
// completes it goes on to median pick and emit, a failed read to emit (no pick). No new
// beat until the last is done. Sort row: one insertion per sample, one indexed read.
// rst is synchronous: sort row empty, zone green, blink bit low, registers at defaults.
// A result waits in the output register; a new beat is accepted meanwhile and only
// the emit step stalls when the previous result has not yet been taken.
module median_hysteresis_thermal_zone (
  input  logic                                 clk,
  input  logic                                 rst,
  mhtz_in_if.sink                              in_ch,
  mhtz_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [mhtz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mhtz_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mhtz_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_PICK,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [WC_W-1:0]          window_count;
  logic [HYST_W-1:0]        hysteresis;
  logic signed [TEMP_W-1:0] crit_high;
  logic signed [TEMP_W-1:0] crit_low;
  logic signed [TEMP_W-1:0] warn_level;
  logic                     sensor_kind;

  // item state
  logic signed [TEMP_W-1:0] raw_q;
  logic                     fail_q;
  logic                     err_q;
  logic [CNT_W-1:0]         held;
  logic [IDX_W-1:0]         pick_idx;
  logic signed [TEMP_W-1:0] med;
  zone_t                    zone_state;
  logic                     blink;

  // output register
  logic                     out_valid;
  logic signed [TEMP_W-1:0] temperature;
  zone_t                    zone;
  logic                     led_green;
  logic                     led_yellow;
  logic                     led_red;
  logic                     sensor_error;

  cell_ctl_t                ctl;
  logic signed [TEMP_W-1:0] key;
  logic signed [TEMP_W-1:0] median;
  logic [CNT_W-1:0]         held_next;
  logic [CLAMP_W-1:0]       clamp;
  logic                     complete;
  logic                     out_free;
  zone_t                    zone_next;
  logic signed [TEMP_W-1:0] hi_hold;
  logic signed [TEMP_W-1:0] lo_hold;
  logic signed [TEMP_W-1:0] wn_hold;
  logic                     hold;

  // type A: x10 as x8 + x2, wrapped to 16 bits
  assign key = sensor_kind ? raw_q : ((raw_q <<< 3) + (raw_q <<< 1));

  assign held_next = held + CNT_W'(1);

  // window count: 0 acts as 1, values above the depth act as the depth
  always_comb begin
    if (window_count == '0) begin
      clamp = CLAMP_W'(1);
    end else if (CLAMP_W'(window_count) > CLAMP_W'(MAX_WINDOW)) begin
      clamp = CLAMP_W'(MAX_WINDOW);
    end else begin
      clamp = CLAMP_W'(window_count);
    end
  end

  assign complete = CLAMP_W'(held_next) >= clamp;

  assign ctl.ins = (state == S_INSERT) && !fail_q;
  assign ctl.clr = ((state == S_INSERT) && fail_q) || (state == S_PICK);

  mhtz_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .key    (key),
    .sel    (pick_idx),
    .median (median)
  );

  // leaving-zone thresholds, each wrapped to 16 bits
  assign hi_hold = crit_high - TEMP_W'(hysteresis);
  assign lo_hold = crit_low + TEMP_W'(hysteresis);
  assign wn_hold = warn_level - TEMP_W'(hysteresis);

  always_comb begin
    unique case (zone_state)
      ZONE_RED_HIGH: hold = med >= hi_hold;
      ZONE_RED_LOW:  hold = med < lo_hold;
      ZONE_YELLOW:   hold = (med >= wn_hold) && (med < crit_high);
      ZONE_GREEN:    hold = 1'b0;
    endcase
    if (hold) begin
      zone_next = zone_state;
    end else if (med >= crit_high) begin
      zone_next = ZONE_RED_HIGH;
    end else if (med < crit_low) begin
      zone_next = ZONE_RED_LOW;
    end else if (med >= warn_level) begin
      zone_next = ZONE_YELLOW;
    end else begin
      zone_next = ZONE_GREEN;
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held         <= '0;
      zone_state   <= ZONE_GREEN;
      blink        <= 1'b0;
      out_valid    <= 1'b0;
      window_count <= WC_W'(1);
      hysteresis   <= '0;
      crit_high    <= 16'sd850;
      crit_low     <= '0;
      warn_level   <= 16'sd700;
      sensor_kind  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_COUNT: window_count <= cfg_data[WC_W-1:0];
          CFG_HYSTERESIS:   hysteresis   <= cfg_data[HYST_W-1:0];
          CFG_CRIT_HIGH:    crit_high    <= cfg_data;
          CFG_CRIT_LOW:     crit_low     <= cfg_data;
          CFG_WARN_LEVEL:   warn_level   <= cfg_data;
          CFG_SENSOR_KIND:  sensor_kind  <= cfg_data[0];
          default: ;
        endcase
      end

      // an emit in the same cycle refills the register instead
      if (out_valid && out_ch.ready && !(state == S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            raw_q  <= in_ch.raw_sample;
            fail_q <= in_ch.read_failed;
            state  <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (fail_q) begin
            // partial window dropped by the row clear
            held  <= '0;
            blink <= ~blink;
            err_q <= 1'b1;
            state <= S_EMIT;
          end else if (complete) begin
            held     <= '0;
            err_q    <= 1'b0;
            pick_idx <= IDX_W'(held_next >> 1);
            state    <= S_PICK;
          end else begin
            held  <= held_next;
            state <= S_IDLE;
          end
        end
        S_PICK: begin
          med   <= median;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (err_q) begin
              temperature  <= ERROR_TEMP;
              zone         <= zone_state;
              led_green    <= 1'b0;
              led_yellow   <= 1'b0;
              led_red      <= blink;
              sensor_error <= 1'b1;
            end else begin
              zone_state   <= zone_next;
              temperature  <= med;
              zone         <= zone_next;
              led_green    <= zone_next == ZONE_GREEN;
              led_yellow   <= zone_next == ZONE_YELLOW;
              led_red      <= (zone_next == ZONE_RED_LOW) || (zone_next == ZONE_RED_HIGH);
              sensor_error <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ch.ready         = state == S_IDLE;
  assign out_ch.valid        = out_valid;
  assign out_ch.temperature  = temperature;
  assign out_ch.zone         = zone;
  assign out_ch.led_green    = led_green;
  assign out_ch.led_yellow   = led_yellow;
  assign out_ch.led_red      = led_red;
  assign out_ch.sensor_error = sensor_error;

endmodule

FILE: src/mhtz_checker.sv
module mhtz_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mhtz_pkg::TEMP_W-1:0] temperature,
  input logic [1:0]                         zone,
  input logic                               led_green,
  input logic                               led_yellow,
  input logic                               led_red,
  input logic                               sensor_error
);
  import mhtz_pkg::*;

  // stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature))
    else $error("result changed while stalled");

  // error beats carry the error temperature and no green or yellow
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && sensor_error |-> temperature == ERROR_TEMP && !led_green && !led_yellow)
    else $error("malformed error result");

  // good beats drive exactly one LED, matching the zone
  a_led_zone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sensor_error |->
      $onehot({led_green, led_yellow, led_red}) && led_red == zone[1] &&
      led_green == (zone == ZONE_GREEN))
    else $error("LED drive does not match zone");

  // one item at a time: no accept in the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind median_hysteresis_thermal_zone mhtz_checker u_mhtz_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .temperature  (out_ch.temperature),
  .zone         (out_ch.zone),
  .led_green    (out_ch.led_green),
  .led_yellow   (out_ch.led_yellow),
  .led_red      (out_ch.led_red),
  .sensor_error (out_ch.sensor_error)
);
